FILE: design/rmx_pkg.sv
// Shared constants and types for the RV32M multiply/divide execute block.
// Used by the register file RAM wrapper users and by the top level.
// Has no dependencies.
package rmx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);
  localparam int unsigned CNT_W     = $clog2(XLEN);
  localparam int unsigned ADD_W     = XLEN + 2;

  // Operation selector carried with each input item.
  typedef enum logic [2:0] {
    MODE_MUL    = 3'd0,
    MODE_MULH   = 3'd1,
    MODE_MULHSU = 3'd2,
    MODE_DIV    = 3'd3,
    MODE_DIVU   = 3'd4,
    MODE_REM    = 3'd5,
    MODE_REMU   = 3'd6,
    MODE_LOAD   = 3'd7
  } rmx_mode_e;

endpackage

FILE: design/rmx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the register file of the execute block; no dependencies.
module rmx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/riscv_m_extension_execute.sv
// Top level of the RV32M multiply/divide execute block with its own register file.
// Depends on rmx_pkg and instantiates rmx_ram for the register file.
//
// Usage: one instruction item enters on the s_axis channel. tuser carries the
// operation mode, tdata the register numbers and the load value. One result item
// per instruction leaves on the m_axis channel: tdata carries the destination
// number and its content after the instruction, tuser the wrote and
// divide-by-zero flags.
// An arithmetic instruction goes through the same sequence: three register file
// reads (one RAM read port), two sign-handling steps, 32 iterations of a radix-2
// shift-add or restoring-divide loop in one shared adder, and one fixup step.
// Loads, writes to register 0 and zero divisors skip the arithmetic: their
// result is registered in the decide step that follows the register file reads.
// The block takes no new item until the current one is done; a finished result
// waits in the output register while the next item is already being worked on,
// and the sequencer holds its last step if that register is still full.
// Reset clears the sequencer, the output valid flag and the per-register valid
// bits, so every register reads as zero right after reset with no clearing pass.
module riscv_m_extension_execute
  import rmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // dest_index[4:0], src1_index[9:5], src2_index[14:10], load_value[46:15], zero pad
  input  logic [47:0] s_axis_tdata_i,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_index[4:0], result_value[36:5], zero pad
  output logic [39:0] m_axis_tdata_o,
  // wrote[0], divide_by_zero[1]
  output logic [1:0]  m_axis_tuser_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD_A   = 8'b0000_0010,
    S_RD_B   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_ABS_A  = 8'b0001_0000,
    S_ABS_B  = 8'b0010_0000,
    S_ITER   = 8'b0100_0000,
    S_FIX    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  rmx_mode_e         mode_q, mode_d;
  logic [IDX_W-1:0]  dest_q, dest_d;
  logic [IDX_W-1:0]  src2_q, src2_d;
  logic [XLEN-1:0]   load_q, load_d;
  logic [XLEN-1:0]   a_q, a_d;
  logic [XLEN-1:0]   b_q, b_d;
  logic [XLEN-1:0]   hi_q, hi_d;
  logic [XLEN-1:0]   lo_q, lo_d;
  logic [XLEN-1:0]   op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_a_q, neg_a_d;
  logic              neg_b_q, neg_b_d;

  logic [REG_COUNT-1:0] valid_q;
  logic                 rd_ok_q;

  logic              m_valid_q;
  logic              m_wrote_q;
  logic              m_dz_q;
  logic [IDX_W-1:0]  m_idx_q;
  logic [XLEN-1:0]   m_val_q;

  logic [IDX_W-1:0]  ram_raddr;
  logic [XLEN-1:0]   ram_rdata;
  logic [XLEN-1:0]   rdv;

  logic              in_fire;
  logic              out_free;
  logic              is_div;
  logic              is_mul;
  logic              sgn_a;
  logic              sgn_b;

  logic              fin;
  logic              fin_wrote;
  logic              fin_dz;
  logic [XLEN-1:0]   fin_val;

  logic [ADD_W-1:0]  add_x;
  logic [ADD_W-1:0]  add_y;
  logic              add_cin;
  logic [ADD_W-1:0]  add_sum;

  logic [XLEN-1:0]   fix_w;
  logic              fix_neg;
  logic              fix_cin;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    is_div = 1'b0;
    is_mul = 1'b0;
    sgn_a  = 1'b0;
    sgn_b  = 1'b0;
    unique case (mode_q) inside
      MODE_MUL:                   is_mul = 1'b1;
      MODE_MULH: begin
        is_mul = 1'b1;
        sgn_a  = 1'b1;
        sgn_b  = 1'b1;
      end
      MODE_MULHSU: begin
        is_mul = 1'b1;
        sgn_a  = 1'b1;
      end
      MODE_DIV, MODE_REM: begin
        is_div = 1'b1;
        sgn_a  = 1'b1;
        sgn_b  = 1'b1;
      end
      MODE_DIVU, MODE_REMU:       is_div = 1'b1;
      default: ;
    endcase
  end

  // Register file: entries never written since reset read as zero.
  always_comb begin
    unique case (state_q)
      S_IDLE:  ram_raddr = s_axis_tdata_i[2*IDX_W-1:IDX_W];
      S_RD_A:  ram_raddr = src2_q;
      default: ram_raddr = dest_q;
    endcase
  end

  rmx_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (fin && fin_wrote),
    .waddr_i (dest_q),
    .wdata_i (fin_val),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rdv = rd_ok_q ? ram_rdata : '0;

  // Final fixup: pick the product half, quotient or remainder, negate if needed.
  // The upper half of a negated product takes a carry only when the lower half is zero.
  always_comb begin
    fix_w   = lo_q;
    fix_neg = 1'b0;
    fix_cin = 1'b1;
    unique case (mode_q) inside
      MODE_MULH, MODE_MULHSU: begin
        fix_w   = hi_q;
        fix_neg = neg_a_q ^ neg_b_q;
        fix_cin = (lo_q == '0);
      end
      MODE_DIV, MODE_DIVU:    fix_neg = neg_a_q ^ neg_b_q;
      MODE_REM, MODE_REMU: begin
        fix_w   = hi_q;
        fix_neg = neg_a_q;
      end
      default: ;
    endcase
  end

  // The one shared adder.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      S_ABS_A: begin
        add_x   = {2'b00, ~a_q};
        add_cin = 1'b1;
      end
      S_ABS_B: begin
        add_x   = {2'b00, ~b_q};
        add_cin = 1'b1;
      end
      S_ITER: begin
        if (is_div) begin
          add_x   = {1'b0, hi_q, lo_q[XLEN-1]};
          add_y   = {2'b11, ~op_q};
          add_cin = 1'b1;
        end else begin
          add_x = {2'b00, hi_q};
          add_y = lo_q[0] ? {2'b00, op_q} : '0;
        end
      end
      S_FIX: begin
        add_x   = {2'b00, ~fix_w};
        add_cin = fix_cin;
      end
      default: ;
    endcase
  end

  assign add_sum = add_x + add_y + ADD_W'(add_cin);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    dest_d    = dest_q;
    src2_d    = src2_q;
    load_d    = load_q;
    a_d       = a_q;
    b_d       = b_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    op_d      = op_q;
    cnt_d     = cnt_q;
    neg_a_d   = neg_a_q;
    neg_b_d   = neg_b_q;
    fin       = 1'b0;
    fin_wrote = 1'b0;
    fin_dz    = 1'b0;
    fin_val   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d  = rmx_mode_e'(s_axis_tuser_i);
          dest_d  = s_axis_tdata_i[IDX_W-1:0];
          src2_d  = s_axis_tdata_i[3*IDX_W-1:2*IDX_W];
          load_d  = s_axis_tdata_i[3*IDX_W+XLEN-1:3*IDX_W];
          state_d = S_RD_A;
        end
      end
      S_RD_A: begin
        a_d     = rdv;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        b_d     = rdv;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        neg_a_d = sgn_a && a_q[XLEN-1];
        neg_b_d = sgn_b && b_q[XLEN-1];
        if (dest_q == '0) begin
          fin = out_free;
        end else if (is_div && (b_q == '0)) begin
          // Zero divisor: the destination keeps its old content.
          fin     = out_free;
          fin_dz  = 1'b1;
          fin_val = rdv;
        end else if (mode_q == MODE_LOAD) begin
          fin       = out_free;
          fin_wrote = 1'b1;
          fin_val   = load_q;
        end else begin
          state_d = S_ABS_A;
        end
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      S_ABS_A: begin
        if (neg_a_q) begin
          a_d = add_sum[XLEN-1:0];
        end
        state_d = S_ABS_B;
      end
      S_ABS_B: begin
        b_d   = neg_b_q ? add_sum[XLEN-1:0] : b_q;
        hi_d  = '0;
        cnt_d = CNT_W'(XLEN - 1);
        if (is_mul) begin
          lo_d = b_d;
          op_d = a_q;
        end else begin
          lo_d = a_q;
          op_d = b_d;
        end
        state_d = S_ITER;
      end
      S_ITER: begin
        if (is_div) begin
          // Restoring step: keep the shifted remainder when the subtract borrows.
          if (add_sum[ADD_W-1]) begin
            hi_d = {hi_q[XLEN-2:0], lo_q[XLEN-1]};
          end else begin
            hi_d = add_sum[XLEN-1:0];
          end
          lo_d = {lo_q[XLEN-2:0], ~add_sum[ADD_W-1]};
        end else begin
          hi_d = add_sum[XLEN:1];
          lo_d = {add_sum[0], lo_q[XLEN-1:1]};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (out_free) begin
          fin       = 1'b1;
          fin_wrote = 1'b1;
          fin_val   = fix_neg ? add_sum[XLEN-1:0] : fix_w;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      rd_ok_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= valid_q[ram_raddr];
      if (fin && fin_wrote) begin
        valid_q[dest_q] <= 1'b1;
      end
      if (fin) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    dest_q  <= dest_d;
    src2_q  <= src2_d;
    load_q  <= load_d;
    a_q     <= a_d;
    b_q     <= b_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    neg_a_q <= neg_a_d;
    neg_b_q <= neg_b_d;
    if (fin) begin
      m_wrote_q <= fin_wrote;
      m_dz_q    <= fin_dz;
      m_idx_q   <= dest_q;
      m_val_q   <= fin_val;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_val_q, m_idx_q};
  assign m_axis_tuser_o  = {m_dz_q, m_wrote_q};

  // Register zero is never written.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_wrote) |-> (dest_q != '0))
    else $error("write to register zero");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("wrote and divide_by_zero both set");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER && is_div) |-> (hi_q < op_q))
    else $error("partial remainder not below divisor");

  a_loop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER && cnt_q == '0) |=> (state_q == S_FIX))
    else $error("iteration loop did not end in fixup");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q == S_DECIDE) || $past(state_q == S_FIX)))
    else $error("result loaded outside a finishing step");

endmodule
